>>> rtl/rsi_pkg.sv
// Package for the radix string-to-integer parser.
// Holds radix codes, character constants, the character classifier and
// the structs passed between the parser's modules. No dependencies.
`default_nettype none

package rsi_pkg;

  localparam int unsigned VALUE_BITS = 64;
  localparam int unsigned CHAR_BITS  = 8;
  localparam int unsigned DIGIT_BITS = 4;

  localparam logic [CHAR_BITS-1:0] CHAR_NUL        = 8'h00;
  localparam logic [CHAR_BITS-1:0] CHAR_UNDERSCORE = 8'h5f;
  localparam logic [CHAR_BITS-1:0] CHAR_COMMA      = 8'h2c;
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO       = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_ONE        = 8'h31;
  localparam logic [CHAR_BITS-1:0] CHAR_SEVEN      = 8'h37;
  localparam logic [CHAR_BITS-1:0] CHAR_NINE       = 8'h39;
  localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A    = 8'h61;
  localparam logic [CHAR_BITS-1:0] CHAR_LOWER_F    = 8'h66;
  localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A    = 8'h41;
  localparam logic [CHAR_BITS-1:0] CHAR_UPPER_F    = 8'h46;
  localparam logic [DIGIT_BITS-1:0] DIGIT_TEN      = 4'ha;

  typedef enum logic [1:0] {
    RADIX_HEX = 2'd0,
    RADIX_BIN = 2'd1,
    RADIX_OCT = 2'd2,
    RADIX_DEC = 2'd3
  } radix_t;

  typedef enum logic [1:0] {
    CLS_DIGIT,
    CLS_SKIP,
    CLS_STOP
  } cls_kind_t;

  typedef struct packed {
    cls_kind_t             kind;
    logic [DIGIT_BITS-1:0] digit;
  } cls_t;

  typedef struct packed {
    logic                 valid;
    logic [CHAR_BITS-1:0] chr;
  } step_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  stopped;
  } result_t;

  function automatic cls_t classify(input logic [CHAR_BITS-1:0] c, input radix_t mode);
    cls_t r;
    r.kind  = CLS_STOP;
    r.digit = '0;
    if (c == CHAR_UNDERSCORE) begin
      r.kind = CLS_SKIP;
    end else begin
      unique case (mode)
        RADIX_HEX: begin
          if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            r.kind  = CLS_DIGIT;
            r.digit = DIGIT_BITS'(c - CHAR_ZERO);
          end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
            r.kind  = CLS_DIGIT;
            r.digit = DIGIT_TEN + DIGIT_BITS'(c - CHAR_LOWER_A);
          end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            r.kind  = CLS_DIGIT;
            r.digit = DIGIT_TEN + DIGIT_BITS'(c - CHAR_UPPER_A);
          end
        end
        RADIX_BIN: begin
          if (c == CHAR_ZERO || c == CHAR_ONE) begin
            r.kind  = CLS_DIGIT;
            r.digit = DIGIT_BITS'(c - CHAR_ZERO);
          end
        end
        RADIX_OCT: begin
          if (c >= CHAR_ZERO && c <= CHAR_SEVEN) begin
            r.kind  = CLS_DIGIT;
            r.digit = DIGIT_BITS'(c - CHAR_ZERO);
          end
        end
        RADIX_DEC: begin
          if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            r.kind  = CLS_DIGIT;
            r.digit = DIGIT_BITS'(c - CHAR_ZERO);
          end else if (c == CHAR_COMMA) begin
            r.kind = CLS_SKIP;
          end
        end
        default: r.kind = CLS_STOP;
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rsi_acc.sv
// Accumulator stage of the radix string-to-integer parser.
// Classifies one character per step and updates the value and halt flag.
// Depends on rsi_pkg.
`default_nettype none

module rsi_acc (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire rsi_pkg::step_t  step,
  input  wire rsi_pkg::radix_t mode,
  output rsi_pkg::result_t     res
);
  import rsi_pkg::*;

  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                  halted_r, halted_nxt;
  logic [VALUE_BITS-1:0] acc_shifted;
  cls_t                  cls;

  always_comb begin
    cls = classify(step.chr, mode);
  end

  always_comb begin
    unique case (mode)
      RADIX_HEX: acc_shifted = {acc_r[VALUE_BITS-5:0], 4'b0};
      RADIX_BIN: acc_shifted = {acc_r[VALUE_BITS-2:0], 1'b0};
      RADIX_OCT: acc_shifted = {acc_r[VALUE_BITS-4:0], 3'b0};
      RADIX_DEC: acc_shifted = {acc_r[VALUE_BITS-4:0], 3'b0} + {acc_r[VALUE_BITS-2:0], 1'b0};
      default:   acc_shifted = acc_r;
    endcase
  end

  always_comb begin
    acc_nxt    = acc_r;
    halted_nxt = halted_r;
    if (step.valid) begin
      if (step.chr == CHAR_NUL) begin
        acc_nxt    = '0;
        halted_nxt = 1'b0;
      end else if (!halted_r) begin
        unique case (cls.kind)
          CLS_DIGIT: acc_nxt = acc_shifted + VALUE_BITS'(cls.digit);
          CLS_STOP:  halted_nxt = 1'b1;
          CLS_SKIP:  acc_nxt = acc_r;
          default:   acc_nxt = acc_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      halted_r <= 1'b0;
    end else begin
      acc_r    <= acc_nxt;
      halted_r <= halted_nxt;
    end
  end

  assign res.value   = acc_r;
  assign res.stopped = halted_r;

endmodule

`default_nettype wire

>>> rtl/radix_string_to_integer.sv
// Top level of the radix string-to-integer parser.
// Input register, radix mode register and result register around rsi_acc.
// Depends on rsi_pkg and rsi_acc.
//
// Usage: send a string one character per item on in_tdata; a NUL character
// ends it. Each NUL produces one item on out_tdata/out_tuser holding the
// accumulated value and a flag set when a non-digit character cut the number.
// Other characters produce no item. The radix is chosen by a write on the
// cfg channel (0 hex, 1 binary, 2 octal, 3 decimal with commas), which is
// always ready and should be written while no string is in progress.
// Throughput is one character per cycle while in_tready is high; the
// accumulator updates once per cycle with a constant shift, or a times-ten
// add, plus the digit. An accepted NUL passes through the input register and
// then loads the result register with the accumulator's value, which raises
// out_tvalid. When the receiver stalls, the result register holds its item
// and characters keep flowing until a second NUL reaches the input register,
// which then waits and drops in_tready. Reset clears the accumulator, the
// halt flag, the radix mode (to hex) and all valid flags.
`default_nettype none

module radix_string_to_integer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] character
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [63:0] value
  output logic             out_tuser,  // [0] stopped_early
  input  wire logic        cfg_tvalid,
  output logic             cfg_tready,
  input  wire logic [7:0]  cfg_tdata   // [1:0] radix_mode
);
  import rsi_pkg::*;

  logic                  s1_valid_r, s1_valid_nxt;
  logic [CHAR_BITS-1:0]  s1_char_r;
  logic                  s1_adv;
  logic                  s1_fire;
  radix_t                mode_r;
  step_t                 step;
  result_t               res;
  logic                  out_valid_r, out_valid_nxt;
  result_t               out_data_r;

  assign s1_adv    = (s1_char_r != CHAR_NUL) || !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tready) begin
      s1_valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_char_r <= in_tdata;
    end
  end

  assign cfg_tready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= RADIX_HEX;
    end else if (cfg_tvalid && cfg_tready) begin
      mode_r <= radix_t'(cfg_tdata[1:0]);
    end
  end

  assign step.valid = s1_fire;
  assign step.chr   = s1_char_r;

  rsi_acc u_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .mode  (mode_r),
    .res   (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire && s1_char_r == CHAR_NUL) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_char_r == CHAR_NUL) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r.value;
  assign out_tuser  = out_data_r.stopped;

endmodule

`default_nettype wire

>>> rtl/rsi_checker.sv
// Port-level checker for the radix string-to-integer parser.
// Bound to radix_string_to_integer; sees only its ports.
`default_nettype none

module rsi_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [7:0]  in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        cfg_tvalid,
  input wire logic        cfg_tready,
  input wire logic [7:0]  cfg_tdata
);

  // A stalled result item keeps its value and flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

  // With the result register empty, the input side never stalls.
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while result register empty");

  // No result item is shown right after reset.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Configuration writes are never refused.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_tvalid |-> cfg_tready)
    else $error("configuration write refused");

endmodule

bind radix_string_to_integer rsi_checker u_rsi_checker (.*);

`default_nettype wire
